FILE: rtl/iat_pkg.sv
// Shared types and constants for the in-flight ack tracker.
// Used by iat_flight_mem and inflight_ack_tracker; depends on nothing else.
`timescale 1ns / 1ps

package iat_pkg;

  localparam int FLIGHT_DEPTH = 32;
  localparam int SEQ_BITS     = 16;
  localparam int PTR_W        = $clog2(FLIGHT_DEPTH);
  localparam int OCC_W        = $clog2(FLIGHT_DEPTH + 1);
  localparam int TIME_W       = 32;
  localparam int CNT_W        = 32;
  localparam int PADDR_W      = 3;

  localparam logic [31:0] TIMEOUT_RESET = 32'd500;

  typedef logic [SEQ_BITS-1:0] seq_t;
  typedef logic [PTR_W-1:0]    ptr_t;
  typedef logic [OCC_W-1:0]    occ_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_ASSIGNED  = 3'd0,
    KIND_DELIVERED = 3'd1,
    KIND_FAILED    = 3'd2,
    KIND_NOTHING   = 3'd3,
    KIND_FULL      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_TMO
  } st_t;

  typedef enum logic {
    REG_PROCESS_ACKS  = 1'b0,
    REG_TIMEOUT_TICKS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0] dispatch;
    seq_t              seq;
  } flight_entry_t;

  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(FLIGHT_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + ptr_t'(1);
    end
    return r;
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    cnt_t r;
    if (v == '1) begin
      r = v;
    end else begin
      r = v + cnt_t'(1);
    end
    return r;
  endfunction

endpackage

FILE: rtl/iat_flight_mem.sv
// In-flight FIFO storage: sequence number and dispatch tick per entry.
// One write port, one read port with registered read data. Uses iat_pkg.
`timescale 1ns / 1ps

module iat_flight_mem
  import iat_pkg::*;
(
  input  logic          clk,
  input  logic          wr_en,
  input  ptr_t          wr_addr,
  input  flight_entry_t wr_data,
  input  ptr_t          rd_addr,
  output flight_entry_t rd_data
);

  flight_entry_t mem [FLIGHT_DEPTH];
  flight_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/inflight_ack_tracker.sv
// Top level of the sender-side delivery tracker: sequence numbering, the
// in-flight FIFO walk for ack ranges and timeouts, and the APB registers.
// Depends on iat_pkg and iat_flight_mem.
//
// Usage. A request is taken when start is high and busy is low; its fields
// are in_command, in_now, in_ack_start and in_ack_count. Results come out on
// the out_ ports, each for one cycle under out_valid, with out_last on the
// final one of a request. The receiver cannot stall the block.
// A send, or an unused command, gives its single result in the cycle after
// it is taken, and busy stays low, so a request may be taken every cycle.
// An ack-range or timeout request holds busy high while it walks the FIFO
// head step by step, where a step pops the head entry or advances the ack
// cursor, and then closes the walk. A popped entry is held until the next
// pop or the close of the walk shows whether it is the last, and leaves in
// the cycle after that, so the last result leaves in the same cycle that
// busy falls. The head entry is read from the FIFO memory every cycle at
// the next head pointer, so each step sees the entry it needs.
// Reset (rst_n low, synchronous) empties the FIFO, clears the counters and
// the sequence number, and sets process_acks to 1 and timeout_ticks to 500.
// Configuration is written through the APB port; the user must write it
// only while the block is idle, as the block itself does not enforce this.
`timescale 1ns / 1ps

module inflight_ack_tracker
  import iat_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_command,
  input  logic [TIME_W-1:0]  in_now,
  input  seq_t               in_ack_start,
  input  logic [7:0]         in_ack_count,
  // result channel
  output logic               out_valid,
  output logic [2:0]         out_kind,
  output seq_t               out_seq,
  output logic               out_last,
  output cnt_t               out_delivered_total,
  output cnt_t               out_dropped_total,
  output cnt_t               out_dispatched_total,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int CUR_W = SEQ_BITS + 1;

  // Configuration registers.
  logic              process_acks_r;
  logic [TIME_W-1:0] timeout_ticks_r;

  // Control state.
  st_t               state_r, state_nxt;
  seq_t              next_out_r, next_out_nxt;
  ptr_t              head_r, head_nxt;
  ptr_t              tail_r, tail_nxt;
  occ_t              occ_r, occ_nxt;
  cnt_t              dlv_r, dlv_nxt;
  cnt_t              drp_r, drp_nxt;
  cnt_t              dsp_r, dsp_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Payload registers.
  logic [CUR_W-1:0]  cursor_r, cursor_nxt;
  logic [CUR_W-1:0]  end_r, end_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  kind_t             pend_kind_r, pend_kind_nxt;
  seq_t              pend_seq_r, pend_seq_nxt;
  cnt_t              pend_dlv_r, pend_dlv_nxt;
  cnt_t              pend_drp_r, pend_drp_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  seq_t              out_seq_r, out_seq_nxt;
  logic              out_last_r, out_last_nxt;
  cnt_t              out_dlv_r, out_dlv_nxt;
  cnt_t              out_drp_r, out_drp_nxt;
  cnt_t              out_dsp_r, out_dsp_nxt;

  // Memory interface.
  logic              mem_wr_en;
  flight_entry_t     mem_wr_data;
  flight_entry_t     head_entry;

  logic              accept;
  logic              cfg_wr;
  logic [TIME_W:0]   due;
  logic              pop;
  kind_t             pop_kind;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_PROCESS_ACKS:  prdata = {31'd0, process_acks_r};
      REG_TIMEOUT_TICKS: prdata = timeout_ticks_r;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      process_acks_r  <= 1'b1;
      timeout_ticks_r <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx_t'(paddr[2]))
        REG_PROCESS_ACKS:  process_acks_r  <= pwdata[0];
        REG_TIMEOUT_TICKS: timeout_ticks_r <= pwdata;
        default: ;
      endcase
    end
  end

  // The read address is the head pointer as it will stand after this edge,
  // so the registered read data always holds the current head entry. A send
  // writes at the edge it is taken, and no walk can start on that same edge,
  // so the read that follows already sees the new entry.
  iat_flight_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (tail_r),
    .wr_data (mem_wr_data),
    .rd_addr (head_nxt),
    .rd_data (head_entry)
  );

  assign due = {1'b0, head_entry.dispatch} + {1'b0, timeout_ticks_r};

  always_comb begin
    state_nxt      = state_r;
    next_out_nxt   = next_out_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    occ_nxt        = occ_r;
    dlv_nxt        = dlv_r;
    drp_nxt        = drp_r;
    dsp_nxt        = dsp_r;
    pend_valid_nxt = pend_valid_r;
    out_valid_nxt  = 1'b0;
    cursor_nxt     = cursor_r;
    end_nxt        = end_r;
    now_nxt        = now_r;
    pend_kind_nxt  = pend_kind_r;
    pend_seq_nxt   = pend_seq_r;
    pend_dlv_nxt   = pend_dlv_r;
    pend_drp_nxt   = pend_drp_r;
    out_kind_nxt   = out_kind_r;
    out_seq_nxt    = out_seq_r;
    out_last_nxt   = out_last_r;
    out_dlv_nxt    = out_dlv_r;
    out_drp_nxt    = out_drp_r;
    out_dsp_nxt    = out_dsp_r;
    mem_wr_en      = 1'b0;
    mem_wr_data    = '{dispatch: in_now, seq: next_out_r};
    pop            = 1'b0;
    pop_kind       = KIND_FAILED;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_t'(in_command))
            CMD_SEND: begin
              next_out_nxt  = next_out_r + seq_t'(1);
              dsp_nxt       = sat_inc(dsp_r);
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_ASSIGNED;
              out_seq_nxt   = next_out_r;
              out_last_nxt  = 1'b1;
              out_dlv_nxt   = dlv_r;
              out_drp_nxt   = drp_r;
              out_dsp_nxt   = sat_inc(dsp_r);
              if (process_acks_r) begin
                if (occ_r < occ_t'(FLIGHT_DEPTH)) begin
                  mem_wr_en = 1'b1;
                  tail_nxt  = ptr_next(tail_r);
                  occ_nxt   = occ_r + occ_t'(1);
                end else begin
                  out_kind_nxt = KIND_FULL;
                end
              end
            end
            CMD_ACK: begin
              state_nxt      = ST_ACK;
              cursor_nxt     = {1'b0, in_ack_start};
              end_nxt        = {1'b0, in_ack_start} + CUR_W'(in_ack_count);
              pend_valid_nxt = 1'b0;
            end
            CMD_TIMEOUT: begin
              state_nxt      = ST_TMO;
              now_nxt        = in_now;
              pend_valid_nxt = 1'b0;
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_NOTHING;
              out_seq_nxt   = '0;
              out_last_nxt  = 1'b1;
              out_dlv_nxt   = dlv_r;
              out_drp_nxt   = drp_r;
              out_dsp_nxt   = dsp_r;
            end
          endcase
        end
      end
      ST_ACK: begin
        if (cursor_r < end_r && occ_r != '0) begin
          if ({1'b0, head_entry.seq} < cursor_r) begin
            pop      = 1'b1;
            pop_kind = KIND_FAILED;
          end else if ({1'b0, head_entry.seq} == cursor_r) begin
            pop        = 1'b1;
            pop_kind   = KIND_DELIVERED;
            cursor_nxt = cursor_r + CUR_W'(1);
          end else begin
            cursor_nxt = cursor_r + CUR_W'(1);
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TMO: begin
        if (occ_r != '0 && due < {1'b0, now_r}) begin
          pop      = 1'b1;
          pop_kind = KIND_FAILED;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A popped entry waits in the pending stage until the next pop or the
    // end of the walk shows whether it is the last result of the request.
    if (pop) begin
      head_nxt = ptr_next(head_r);
      occ_nxt  = occ_r - occ_t'(1);
      if (pop_kind == KIND_DELIVERED) begin
        dlv_nxt = sat_inc(dlv_r);
      end else begin
        drp_nxt = sat_inc(drp_r);
      end
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = pend_kind_r;
        out_seq_nxt   = pend_seq_r;
        out_last_nxt  = 1'b0;
        out_dlv_nxt   = pend_dlv_r;
        out_drp_nxt   = pend_drp_r;
        out_dsp_nxt   = dsp_r;
      end
      pend_valid_nxt = 1'b1;
      pend_kind_nxt  = pop_kind;
      pend_seq_nxt   = head_entry.seq;
      pend_dlv_nxt   = dlv_nxt;
      pend_drp_nxt   = drp_nxt;
    end else if (state_r != ST_IDLE && state_nxt == ST_IDLE) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = 1'b1;
      out_dsp_nxt    = dsp_r;
      pend_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        out_kind_nxt = pend_kind_r;
        out_seq_nxt  = pend_seq_r;
        out_dlv_nxt  = pend_dlv_r;
        out_drp_nxt  = pend_drp_r;
      end else begin
        out_kind_nxt = KIND_NOTHING;
        out_seq_nxt  = '0;
        out_dlv_nxt  = dlv_r;
        out_drp_nxt  = drp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      next_out_r   <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      occ_r        <= '0;
      dlv_r        <= '0;
      drp_r        <= '0;
      dsp_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_out_r   <= next_out_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      occ_r        <= occ_nxt;
      dlv_r        <= dlv_nxt;
      drp_r        <= drp_nxt;
      dsp_r        <= dsp_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r    <= cursor_nxt;
    end_r       <= end_nxt;
    now_r       <= now_nxt;
    pend_kind_r <= pend_kind_nxt;
    pend_seq_r  <= pend_seq_nxt;
    pend_dlv_r  <= pend_dlv_nxt;
    pend_drp_r  <= pend_drp_nxt;
    out_kind_r  <= out_kind_nxt;
    out_seq_r   <= out_seq_nxt;
    out_last_r  <= out_last_nxt;
    out_dlv_r   <= out_dlv_nxt;
    out_drp_r   <= out_drp_nxt;
    out_dsp_r   <= out_dsp_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_kind             = out_kind_r;
  assign out_seq              = out_seq_r;
  assign out_last             = out_last_r;
  assign out_delivered_total  = out_dlv_r;
  assign out_dropped_total    = out_drp_r;
  assign out_dispatched_total = out_dsp_r;

endmodule
